// ----- rtl/circular_arc_step_generator_assert.svh -----
// assertion macros for the circular arc step generator
`ifndef CIRCULAR_ARC_STEP_GENERATOR_ASSERT_SVH
`define CIRCULAR_ARC_STEP_GENERATOR_ASSERT_SVH
`ifndef SYNTH
`define CAS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define CAS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CAS_ASSERT(label, prop)
`define CAS_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- rtl/cas_pkg.sv -----
// types, constants and tables shared by the arc step generator
package cas_pkg;
  localparam int STEPS_PER_RADIAN = 10;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int INNER_FRAC = 30;
  localparam int MAX_MOVES = 62;
  localparam int ANG_W = 36;
  localparam int XY_W = 34;
  localparam int PT_W = 18;
  localparam int N_W = 6;
  localparam int REM_W = 5;
  localparam int PROD_W = XY_W + 16;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;

  // angle of one step, split into quotient and remainder of 2^30 / steps
  localparam logic [ANG_W-1:0] STEP_Q = ANG_W'((64'd1 << INNER_FRAC) / STEPS_PER_RADIAN);
  localparam logic [REM_W-1:0] STEP_R = REM_W'((64'd1 << INNER_FRAC) % STEPS_PER_RADIAN);
  localparam logic [REM_W-1:0] STEP_DIV = REM_W'(STEPS_PER_RADIAN);

  localparam logic [1:0] KIND_MOVE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic                    op;
    logic                    zero;
    logic                    neg;
    logic [N_W-1:0]          n;
    logic signed [ANG_W-1:0] theta;
    logic [14:0]             radius;
    logic signed [15:0]      cdx;
    logic signed [15:0]      cdy;
  } cmd_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] k);
    logic signed [ANG_W-1:0] v;
    case (k)
      5'd0: v = 36'sd843314857;
      5'd1: v = 36'sd497837830;
      5'd2: v = 36'sd263043837;
      5'd3: v = 36'sd133525159;
      5'd4: v = 36'sd67021687;
      5'd5: v = 36'sd33543516;
      5'd6: v = 36'sd16775851;
      5'd7: v = 36'sd8388437;
      5'd8: v = 36'sd4194283;
      5'd9: v = 36'sd2097149;
      5'd10: v = 36'sd1048576;
      5'd11: v = 36'sd524288;
      5'd12: v = 36'sd262144;
      5'd13: v = 36'sd131072;
      5'd14: v = 36'sd65536;
      5'd15: v = 36'sd32768;
      5'd16: v = 36'sd16384;
      5'd17: v = 36'sd8192;
      5'd18: v = 36'sd4096;
      5'd19: v = 36'sd2048;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// ----- rtl/cas_front.sv -----
// front end: takes arc commands, classifies them and queues them for the back end
module cas_front import cas_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [14:0] start_angle,
  input  logic signed [15:0] arc_length,
  input  logic [14:0]        radius,
  input  logic signed [15:0] centre_dx,
  input  logic signed [15:0] centre_dy,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output cmd_t               cmd
);
  logic [15:0] mag;
  logic [19:0] scaled;
  logic [19:0] n_full;
  cmd_t        cls;
  cmd_t        q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  always_comb begin
    mag = arc_length[15] ? 16'(-arc_length) : 16'(arc_length);
    scaled = 20'(mag) * 20'(STEPS_PER_RADIAN);
    n_full = scaled >> ANGLE_FRAC_BITS;
    cls.op = op;
    cls.zero = (arc_length == '0);
    cls.neg = arc_length[15];
    cls.n = (n_full > 20'(MAX_MOVES)) ? N_W'(MAX_MOVES) : n_full[N_W-1:0];
    cls.theta = ANG_W'(start_angle) <<< (INNER_FRAC - ANGLE_FRAC_BITS);
    cls.radius = radius;
    cls.cdx = centre_dx;
    cls.cdy = centre_dy;
  end

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = cmd_pop && (count != 2'd0);
  assign cmd_valid = (count != 2'd0);

  // head entry goes out directly so it lines up with cmd_valid
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- rtl/cas_cordic.sv -----
// iterative rotation cordic giving cos and sin of a folded angle
module cas_cordic import cas_pkg::*; #(
  parameter int ITERS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    done,
  output logic signed [XY_W-1:0]  cos_q,
  output logic signed [XY_W-1:0]  sin_q
);
  localparam int KW = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [ANG_W-1:0] z;
  logic [KW-1:0]           k;
  logic                    running;
  logic signed [ANG_W-1:0] step_ang;

  assign step_ang = atan_q30(5'(k));
  assign cos_q = x;
  assign sin_q = y;

  always_ff @(posedge clk) begin
    if (start) begin
      x <= GAIN_Q30;
      y <= '0;
      z <= angle;
    end else if (running) begin
      if (z >= 0) begin
        x <= x - (y >>> k);
        y <= y + (x >>> k);
        z <= z - step_ang;
      end else begin
        x <= x + (y >>> k);
        y <= y - (x >>> k);
        z <= z + step_ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      k <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        k <= '0;
      end else if (running) begin
        k <= k + 1'b1;
        if (k == KW'(ITERS - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/cas_back.sv -----
// back end: walks the arc point by point and emits the pen moves
module cas_back import cas_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_pop,
  input  cmd_t                   cmd,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PT_W-1:0] move_dx,
  output logic signed [PT_W-1:0] move_dy,
  output logic [1:0]             kind,
  output logic                   last
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ANGLE = 4'd1;
  localparam logic [3:0] S_REDUCE = 4'd2;
  localparam logic [3:0] S_FOLD = 4'd3;
  localparam logic [3:0] S_CORDIC = 4'd4;
  localparam logic [3:0] S_MULX = 4'd5;
  localparam logic [3:0] S_MULY = 4'd6;
  localparam logic [3:0] S_ROUND = 4'd7;
  localparam logic [3:0] S_POINT = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;
  localparam logic [3:0] S_NEXT = 4'd10;

  logic [3:0]               state;
  cmd_t                     cmd_r;
  logic [N_W-1:0]           step;
  logic [ANG_W-1:0]         accq;
  logic [REM_W-1:0]         accr;
  logic [REM_W-1:0]         rem_sum;
  logic signed [ANG_W-1:0]  ang;
  logic signed [ANG_W-1:0]  fold_ang;
  logic                     fold_flip;
  logic                     flip;
  logic signed [PROD_W-1:0] prod;
  logic signed [PT_W-1:0]   px;
  logic signed [PT_W-1:0]   py;
  logic signed [PT_W-1:0]   prevx;
  logic signed [PT_W-1:0]   prevy;
  logic signed [PT_W-1:0]   em_dx;
  logic signed [PT_W-1:0]   em_dy;
  logic [1:0]               em_kind;
  logic                     em_last;
  logic                     cordic_start;
  logic                     cordic_done;
  logic signed [XY_W-1:0]   cos_q;
  logic signed [XY_W-1:0]   sin_q;
  logic signed [XY_W-1:0]   cos_s;
  logic signed [XY_W-1:0]   sin_s;
  logic signed [15:0]       rad_s;
  logic                     load;

  function automatic logic signed [PT_W-1:0] round_q(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sh;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    sh = (mag + (PROD_W'(1) << (INNER_FRAC - 1))) >> INNER_FRAC;
    return v[PROD_W-1] ? -PT_W'(sh) : PT_W'(sh);
  endfunction

  cas_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (fold_ang),
    .done  (cordic_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // fold into [-pi/2, pi/2], the flip negates cos and sin afterwards
  always_comb begin
    if (ang > HALF_PI_Q30) begin
      fold_ang = ang - PI_Q30;
      fold_flip = 1'b1;
    end else if (ang < -HALF_PI_Q30) begin
      fold_ang = ang + PI_Q30;
      fold_flip = 1'b1;
    end else begin
      fold_ang = ang;
      fold_flip = 1'b0;
    end
  end

  assign cordic_start = (state == S_FOLD);
  assign cos_s = flip ? -cos_q : cos_q;
  assign sin_s = flip ? -sin_q : sin_q;
  assign rad_s = signed'({1'b0, cmd_r.radius});
  assign rem_sum = accr + STEP_R;
  assign cmd_pop = (state == S_IDLE);
  assign load = (state == S_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r <= cmd;
        ang <= cmd.theta;
        accq <= '0;
        accr <= '0;
        em_dx <= '0;
        em_dy <= '0;
        em_kind <= KIND_REJECT;
        em_last <= 1'b1;
      end
      S_ANGLE: ang <= cmd_r.neg ? cmd_r.theta - signed'(accq) : cmd_r.theta + signed'(accq);
      S_REDUCE: begin
        if (ang >= PI_Q30) ang <= ang - TWO_PI_Q30;
        else if (ang < -PI_Q30) ang <= ang + TWO_PI_Q30;
      end
      S_FOLD: flip <= fold_flip;
      S_MULX: prod <= PROD_W'(rad_s) * PROD_W'(cos_s);
      S_MULY: begin
        px <= round_q(prod);
        prod <= PROD_W'(rad_s) * PROD_W'(sin_s);
      end
      S_ROUND: py <= round_q(prod);
      S_POINT: begin
        prevx <= px;
        prevy <= py;
        em_kind <= KIND_MOVE;
        em_last <= 1'b0;
        if (step == '0) begin
          em_dx <= PT_W'(cmd_r.cdx) + px;
          em_dy <= PT_W'(cmd_r.cdy) + py;
        end else begin
          em_dx <= px - prevx;
          em_dy <= py - prevy;
        end
      end
      S_NEXT: begin
        if (step == cmd_r.n) begin
          em_dx <= '0;
          em_dy <= '0;
          em_kind <= KIND_DONE;
          em_last <= 1'b1;
        end else if (rem_sum >= STEP_DIV) begin
          accr <= rem_sum - STEP_DIV;
          accq <= accq + STEP_Q + 1'b1;
        end else begin
          accr <= rem_sum;
          accq <= accq + STEP_Q;
        end
      end
      default: ;
    endcase
    if (load) begin
      move_dx <= em_dx;
      move_dy <= em_dy;
      kind <= em_kind;
      last <= em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (cmd_valid) state <= cmd.zero ? S_EMIT : S_REDUCE;
        end
        S_ANGLE: state <= S_REDUCE;
        S_REDUCE: begin
          if (ang < PI_Q30 && ang >= -PI_Q30) state <= S_FOLD;
        end
        S_FOLD: state <= S_CORDIC;
        S_CORDIC: if (cordic_done) state <= S_MULX;
        S_MULX: state <= S_MULY;
        S_MULY: state <= S_ROUND;
        S_ROUND: state <= S_POINT;
        S_POINT: begin
          // start point only yields a move when the head comes from the centre offset
          if (step == '0 && !cmd_r.op) state <= S_NEXT;
          else state <= S_EMIT;
        end
        S_EMIT: begin
          if (load) state <= em_last ? S_IDLE : S_NEXT;
        end
        S_NEXT: begin
          if (step == cmd_r.n) begin
            state <= S_EMIT;
          end else begin
            step <= step + 1'b1;
            state <= S_ANGLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "circular_arc_step_generator_assert.svh"
  `CAS_ASSERT(a_last_on_status, out_valid |-> ((kind == KIND_MOVE) != last))
  `CAS_ASSERT(a_fold_in_range, (state == S_FOLD) |-> (fold_ang <= HALF_PI_Q30 && fold_ang >= -HALF_PI_Q30))
  `CAS_ASSERT(a_step_bound, (state != S_IDLE) |-> (step <= cmd_r.n))
  `CAS_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid)
endmodule

// ----- rtl/circular_arc_step_generator.sv -----
// circular arc step generator: splits arc commands into pen moves
// each circle point runs the cordic and the sequencer states; angle wrap and output stalls add to it
// a nonzero command computes n + 1 circle points, n = arc steps (at most 62)
// first result: for op 1 the move from the centre offset to the start point, for op 0 after the second point
// a zero arc is answered with a reject status and no points; two commands can wait in the front queue
// synchronous reset clears the queue, the sequencer and the output valid
module circular_arc_step_generator import cas_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [14:0] start_angle,
  input  logic signed [15:0] arc_length,
  input  logic [14:0]        radius,
  input  logic signed [15:0] centre_dx,
  input  logic signed [15:0] centre_dy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] move_dx,
  output logic signed [17:0] move_dy,
  output logic [1:0]         kind,
  output logic               last
);
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  cas_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .start_angle (start_angle),
    .arc_length  (arc_length),
    .radius      (radius),
    .centre_dx   (centre_dx),
    .centre_dy   (centre_dy),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd)
  );

  cas_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .move_dx   (move_dx),
    .move_dy   (move_dy),
    .kind      (kind),
    .last      (last)
  );
endmodule
